// ----- rtl/core/point_in_convex_quad_assert.svh -----
// Assertion macros used by the point-in-quad top level.
// Needs i_clk and i_rst_n in the scope where the macros are used.
`ifndef POINT_IN_CONVEX_QUAD_ASSERT_SVH
`define POINT_IN_CONVEX_QUAD_ASSERT_SVH

// Condition in the current cycle implies a consequence in the same cycle.
`define PCQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pcq assertion failed");

// Condition must never be seen.
`define PCQ_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("pcq assertion failed");

`endif

// ----- rtl/core/pcq_pkg.sv -----
// Shared constants and types of the point-in-quad block.
// No dependencies.
package pcq_pkg;

    // Coordinate width of corners and points.
    localparam int COORD_BITS = 16;
    // Edge differences, products and cross product widths.
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;

    localparam int NUM_CORNERS = 4;
    // Two register stages per edge cell.
    localparam int LATENCY     = 2 * NUM_CORNERS;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_C0X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_C0Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_C1X = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_C1Y = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_C2X = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_C2Y = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_C3X = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_C3Y = 3'd7;

    // Request state handed from one edge cell to the next.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic                         done;      // decision already made
        logic                         result;    // inside flag
        logic                         sign_set;  // first nonzero sign seen
        logic                         sign_neg;  // that sign was negative
    } t_pcq_tok;

endpackage

// ----- rtl/core/pcq_cell.sv -----
// One edge cell: cross product of the point against edge a-b, two stages.
// Depends on pcq_pkg.
module pcq_cell (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic signed [pcq_pkg::COORD_BITS-1:0] i_ax,
    input  logic signed [pcq_pkg::COORD_BITS-1:0] i_ay,
    input  logic signed [pcq_pkg::COORD_BITS-1:0] i_bx,
    input  logic signed [pcq_pkg::COORD_BITS-1:0] i_by,
    input  logic                                  i_vld,
    input  pcq_pkg::t_pcq_tok                     i_tok,
    output logic                                  o_vld,
    output pcq_pkg::t_pcq_tok                     o_tok
);

    localparam int CB = pcq_pkg::COORD_BITS;
    localparam int DW = pcq_pkg::DIFF_BITS;
    localparam int PW = pcq_pkg::PROD_BITS;
    localparam int KW = pcq_pkg::CROSS_BITS;

    logic signed [DW-1:0] w_dpx, w_dpy, w_dbx, w_dby;
    logic signed [PW-1:0] n_pa, n_pb, r_pa, r_pb;
    logic signed [CB-1:0] w_xlo, w_xhi, w_ylo, w_yhi;
    logic                 n_box, r_box;
    logic                 r_vld1, r_vld2;
    pcq_pkg::t_pcq_tok    r_tok1, r_tok2, n_tok2;
    logic signed [KW-1:0] w_k;
    logic                 w_zero, w_neg;

    // Stage 1: differences, both products, bounding box test
    always_comb begin
        w_dpx = {i_tok.px[CB-1], i_tok.px} - {i_ax[CB-1], i_ax};
        w_dpy = {i_tok.py[CB-1], i_tok.py} - {i_ay[CB-1], i_ay};
        w_dbx = {i_bx[CB-1], i_bx} - {i_ax[CB-1], i_ax};
        w_dby = {i_by[CB-1], i_by} - {i_ay[CB-1], i_ay};
        n_pa  = w_dpy * w_dbx;
        n_pb  = w_dpx * w_dby;
        w_xlo = (i_ax < i_bx) ? i_ax : i_bx;
        w_xhi = (i_ax > i_bx) ? i_ax : i_bx;
        w_ylo = (i_ay < i_by) ? i_ay : i_by;
        w_yhi = (i_ay > i_by) ? i_ay : i_by;
        n_box = (i_tok.px >= w_xlo) && (i_tok.px <= w_xhi) &&
                (i_tok.py >= w_ylo) && (i_tok.py <= w_yhi);
    end

    // Stage 2: cross product sign and decision update
    always_comb begin
        w_k    = {r_pa[PW-1], r_pa} - {r_pb[PW-1], r_pb};
        w_zero = (w_k == '0);
        w_neg  = w_k[KW-1];
        n_tok2 = r_tok1;
        if (!r_tok1.done) begin
            if (w_zero) begin
                if (r_box) begin
                    n_tok2.done   = 1'b1;
                    n_tok2.result = 1'b1;
                end
            end else if (!r_tok1.sign_set) begin
                n_tok2.sign_set = 1'b1;
                n_tok2.sign_neg = w_neg;
            end else if (r_tok1.sign_neg != w_neg) begin
                n_tok2.done   = 1'b1;
                n_tok2.result = 1'b0;
            end
        end
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_tok1 <= i_tok;
        r_pa   <= n_pa;
        r_pb   <= n_pb;
        r_box  <= n_box;
        r_tok2 <= n_tok2;
    end

    assign o_vld = r_vld2;
    assign o_tok = r_tok2;

endmodule

// ----- rtl/core/point_in_convex_quad.sv -----
// A request is accepted with start high; its result comes back with the o_valid strobe.
// Throughput: one point per cycle; busy is always low, the result cannot be stalled.
// The rate comes from a chain of edge cells, each a multiply stage then a
// subtract-and-decide stage. Reset clears the corners to zero and all valid flags.
// Top level of the point-in-quad test; depends on pcq_pkg, pcq_cell and
// point_in_convex_quad_assert.svh.
`include "point_in_convex_quad_assert.svh"
module point_in_convex_quad (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [pcq_pkg::CFG_IDX_BITS-1:0]         i_cfg_idx,
    input  logic [pcq_pkg::COORD_BITS-1:0]           i_cfg_data,
    input  logic                                     start,
    output logic                                     busy,
    input  logic signed [pcq_pkg::COORD_BITS-1:0]    i_point_x,
    input  logic signed [pcq_pkg::COORD_BITS-1:0]    i_point_y,
    output logic                                     o_valid,
    output logic                                     o_inside_res
);

    localparam int NC = pcq_pkg::NUM_CORNERS;

    logic signed [pcq_pkg::COORD_BITS-1:0] r_cx [NC];
    logic signed [pcq_pkg::COORD_BITS-1:0] r_cy [NC];
    logic                                  w_vld [NC+1];
    pcq_pkg::t_pcq_tok                     w_tok [NC+1];

    // Corner registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NC; i++) begin
                r_cx[i] <= '0;
                r_cy[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcq_pkg::REG_C0X: r_cx[0] <= i_cfg_data;
                pcq_pkg::REG_C0Y: r_cy[0] <= i_cfg_data;
                pcq_pkg::REG_C1X: r_cx[1] <= i_cfg_data;
                pcq_pkg::REG_C1Y: r_cy[1] <= i_cfg_data;
                pcq_pkg::REG_C2X: r_cx[2] <= i_cfg_data;
                pcq_pkg::REG_C2Y: r_cy[2] <= i_cfg_data;
                pcq_pkg::REG_C3X: r_cx[3] <= i_cfg_data;
                pcq_pkg::REG_C3Y: r_cy[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Fresh request enters the chain with no sign seen
    assign busy = 1'b0;
    always_comb begin
        w_vld[0]          = start;
        w_tok[0].px       = i_point_x;
        w_tok[0].py       = i_point_y;
        w_tok[0].done     = 1'b0;
        w_tok[0].result   = 1'b1;
        w_tok[0].sign_set = 1'b0;
        w_tok[0].sign_neg = 1'b0;
    end

    // Edge cells 0-1, 1-2, 2-3, 3-0
    for (genvar e = 0; e < NC; e++) begin : g_edge
        pcq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ax    (r_cx[e]),
            .i_ay    (r_cy[e]),
            .i_bx    (r_cx[(e + 1) % NC]),
            .i_by    (r_cy[(e + 1) % NC]),
            .i_vld   (w_vld[e]),
            .i_tok   (w_tok[e]),
            .o_vld   (w_vld[e+1]),
            .o_tok   (w_tok[e+1])
        );
    end

    assign o_valid      = w_vld[NC];
    assign o_inside_res = w_tok[NC].result;

    // Assertions
    `PCQ_ASSERT_IMPL(a_latency, o_valid, $past(start, pcq_pkg::LATENCY))
    `PCQ_ASSERT_NEVER(a_undecided_out, o_valid && !w_tok[NC].done && !w_tok[NC].result)
    `PCQ_ASSERT_IMPL(a_outside_sign, o_valid && !o_inside_res, w_tok[NC].sign_set)

endmodule
